// File: src/cfwm_pkg.sv
// Shared types and constants for the capture FIFO with watermark.
package cfwm_pkg;

    // Fixed widths of the item fields
    localparam int DATA_W = 64;
    localparam int CNT_W  = 7;
    localparam int DROP_W = 32;
    localparam int OP_W   = 3;

    // Operation codes carried in s_axis_tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 3'd0,
        OP_PEEK      = 3'd1,
        OP_POP       = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_HIGHWATER = 3'd4,
        OP_DROP      = 3'd5
    } op_t;

    // Status of one operation, sent from the control unit to the output register
    typedef struct packed {
        logic              head_ok;
        logic              accepted;
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  free;
        logic [DROP_W-1:0] dropped;
        logic [CNT_W-1:0]  watermark;
    } status_t;

endpackage

// File: src/cfwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/cfwm_ctrl.sv
// Pointer, drop counter and watermark logic; drives the entry RAM ports.
module cfwm_ctrl #(
    parameter int DEPTH = 64,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int PTR_W = IDX_W + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [2:0]             opcode,
    output logic                   ram_we,
    output logic [IDX_W-1:0]       ram_waddr,
    output logic                   ram_re,
    output logic [IDX_W-1:0]       ram_raddr,
    output cfwm_pkg::status_t      status
);
    import cfwm_pkg::*;

    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);
    localparam logic [PTR_W-1:0] ONE_P   = PTR_W'(1);

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  peak_reg, peak_next;
    logic [DROP_W-1:0] drop_reg, drop_next;

    logic [PTR_W-1:0]  fill_now;
    logic [PTR_W-1:0]  fill_push;
    logic [PTR_W-1:0]  fill_after;
    logic [PTR_W-1:0]  free_after;
    logic [PTR_W+CNT_W-1:0] fill_ext, free_ext, peak_ext;
    logic              full;
    logic              empty;
    logic              head_ok;
    logic              accepted;
    op_t               op;

    assign op        = op_t'(opcode);
    assign fill_now  = wp_reg - rp_reg;
    assign fill_push = fill_now + ONE_P;
    assign full      = fill_now[PTR_W-1];
    assign empty     = (fill_now == '0);

    // Operation decode and next state
    always_comb begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        peak_next = peak_reg;
        drop_next = drop_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        head_ok   = 1'b0;
        accepted  = 1'b0;
        unique case (op)
            OP_PUSH: begin
                if (full) begin
                    drop_next = drop_reg + 32'd1;
                end else begin
                    ram_we   = accept;
                    accepted = 1'b1;
                    wp_next  = wp_reg + ONE_P;
                    if (fill_push > peak_reg) begin
                        peak_next = fill_push;
                    end
                end
            end
            OP_PEEK: begin
                if (!empty) begin
                    ram_re  = accept;
                    head_ok = 1'b1;
                end
            end
            OP_POP: begin
                if (!empty) begin
                    ram_re  = accept;
                    head_ok = 1'b1;
                    rp_next = rp_reg + ONE_P;
                end
            end
            OP_CLEAR: begin
                wp_next   = '0;
                rp_next   = '0;
                peak_next = '0;
            end
            OP_HIGHWATER: begin
                peak_next = fill_now;
            end
            OP_DROP: begin
                drop_next = drop_reg + 32'd1;
            end
            default: begin
            end
        endcase
    end

    assign ram_waddr = wp_reg[IDX_W-1:0];
    assign ram_raddr = rp_reg[IDX_W-1:0];

    // Status after the operation (watermark as before it), trimmed to the 7-bit fields
    assign fill_after = wp_next - rp_next;
    assign free_after = DEPTH_P - fill_after;
    assign fill_ext   = {{CNT_W{1'b0}}, fill_after};
    assign free_ext   = {{CNT_W{1'b0}}, free_after};
    assign peak_ext   = {{CNT_W{1'b0}}, peak_reg};

    always_comb begin
        status.head_ok   = head_ok;
        status.accepted  = accepted;
        status.fill      = fill_ext[CNT_W-1:0];
        status.free      = free_ext[CNT_W-1:0];
        status.dropped   = drop_next;
        status.watermark = peak_ext[CNT_W-1:0];
    end

    // State registers, updated on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            peak_reg <= '0;
            drop_reg <= '0;
        end else if (accept) begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            peak_reg <= peak_next;
            drop_reg <= drop_next;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_now <= DEPTH_P)
        else $error("fill level above depth");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg <= DEPTH_P)
        else $error("watermark above depth");

    a_ram_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("RAM read and write in one cycle");

    a_push_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ram_we) |=> (wp_reg == $past(wp_reg) + ONE_P))
        else $error("write pointer did not advance on push");
`endif

endmodule

// File: src/capture_fifo_with_watermark.sv
// A result is registered in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the entry RAM read of
// peek and pop completes alongside the pointer update.
// Reset (aresetn low, synchronous): pointers, drop count and watermark clear at once;
// entry RAM contents are not cleared and need no clearing pass.
module capture_fifo_with_watermark #(
    parameter int DEPTH      = 64,
    parameter int ENTRY_BITS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // [63:0] push_data
    input  logic [2:0]   s_axis_tuser,  // [2:0] opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] head_data, [70:64] fill_count, [77:71] free_count,
    // [109:78] dropped_count, [116:110] watermark, [119:117] zero
    output logic [119:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser   // [0] head_valid, [1] push_accepted
);
    import cfwm_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic                  accept;
    logic                  ram_we;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [ENTRY_BITS+DATA_W-1:0] rdata_ext;
    logic [DATA_W-1:0]     head_data;
    status_t               status;
    status_t               status_reg;
    logic                  m_valid_reg, m_valid_next;

    // Input taken whenever the output register is free or being emptied
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cfwm_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .opcode   (s_axis_tuser),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_re   (ram_re),
        .ram_raddr(ram_raddr),
        .status   (status)
    );

    cfwm_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_axis_tdata[ENTRY_BITS-1:0]),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Output valid
    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Status payload, held while the result waits
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
        end
    end

    // Head entry comes straight from the RAM read register
    assign rdata_ext = {{DATA_W{1'b0}}, ram_rdata};
    assign head_data = status_reg.head_ok ? rdata_ext[DATA_W-1:0] : '0;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, status_reg.watermark, status_reg.dropped,
                            status_reg.free, status_reg.fill, head_data};
    assign m_axis_tuser  = {status_reg.accepted, status_reg.head_ok};

`ifndef ASSERT_OFF
    a_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("head data not zero without an entry");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("push and head flags both set");

    a_ram_read_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> accept)
        else $error("RAM read data replaced while result pending");
`endif

endmodule
